// File: rtl/core/sgcv_pkg.sv
package sgcv_pkg;

    // Datapath widths, sized for the largest supported set of 4096 samples
    localparam int N_W     = 13;   // sample count and rank
    localparam int X_W     = 16;   // Q8.8 sample
    localparam int SUM_W   = 29;   // running sum
    localparam int WS_W    = 42;   // rank-weighted sum
    localparam int SQ_W    = 44;   // sum of squares
    localparam int OUT_W   = 32;   // Q16.16 results
    localparam int DVD_W   = 100;  // divider dividend and quotient
    localparam int DVS_W   = 70;   // divider divisor
    localparam int REM_W   = 71;   // divider partial remainder
    localparam int DCNT_W  = 7;    // divider step counter
    localparam int RT_W    = 62;   // square root operand
    localparam int RT_STEPS = 31;  // square root steps
    localparam int RCNT_W  = 5;    // square root step counter

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PROD,
        ST_DIFF,
        ST_PROD2,
        ST_MEAN_LD,
        ST_MEAN_RUN,
        ST_GINI_LD,
        ST_GINI_RUN,
        ST_CV_LD,
        ST_CV_RUN,
        ST_ROOT_LD,
        ST_ROOT_RUN,
        ST_EMIT
    } t_state;

    typedef enum logic [1:0] {
        DIV_MEAN,
        DIV_GINI,
        DIV_CV
    } t_div_src;

    // Controller to datapath commands
    typedef struct packed {
        logic     prod;
        logic     diff;
        logic     prod2;
        logic     div_load;
        t_div_src div_src;
        logic     div_step;
        logic     cap_mean;
        logic     cap_gini;
        logic     root_load;
        logic     root_step;
        logic     emit;
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic div_last;
        logic root_last;
    } t_dp_sts;

endpackage

// File: rtl/core/sgcv_ctrl.sv
module sgcv_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_accept,
    input  logic            i_last_sample,
    input  sgcv_pkg::t_dp_sts i_sts,
    output sgcv_pkg::t_dp_cmd o_cmd,
    output logic            o_busy
);
    import sgcv_pkg::*;

    t_state r_state;
    t_state n_state;

    // Hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Advance through the finishing sequence
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_accept && i_last_sample) n_state = ST_PROD;
            end
            ST_PROD:     n_state = ST_DIFF;
            ST_DIFF:     n_state = ST_PROD2;
            ST_PROD2:    n_state = ST_MEAN_LD;
            ST_MEAN_LD:  n_state = ST_MEAN_RUN;
            ST_MEAN_RUN: begin
                if (i_sts.div_last) n_state = ST_GINI_LD;
            end
            ST_GINI_LD:  n_state = ST_GINI_RUN;
            ST_GINI_RUN: begin
                if (i_sts.div_last) n_state = ST_CV_LD;
            end
            ST_CV_LD:    n_state = ST_CV_RUN;
            ST_CV_RUN: begin
                if (i_sts.div_last) n_state = ST_ROOT_LD;
            end
            ST_ROOT_LD:  n_state = ST_ROOT_RUN;
            ST_ROOT_RUN: begin
                if (i_sts.root_last) n_state = ST_EMIT;
            end
            ST_EMIT:     n_state = ST_IDLE;
            default:     n_state = ST_IDLE;
        endcase
    end

    // Drive datapath commands
    always_comb begin
        o_cmd = '0;
        o_cmd.div_src = DIV_MEAN;
        o_busy = (r_state != ST_IDLE);
        case (r_state)
            ST_PROD:  o_cmd.prod  = 1'b1;
            ST_DIFF:  o_cmd.diff  = 1'b1;
            ST_PROD2: o_cmd.prod2 = 1'b1;
            ST_MEAN_LD: begin
                o_cmd.div_load = 1'b1;
                o_cmd.div_src  = DIV_MEAN;
            end
            ST_GINI_LD: begin
                o_cmd.cap_mean = 1'b1;
                o_cmd.div_load = 1'b1;
                o_cmd.div_src  = DIV_GINI;
            end
            ST_CV_LD: begin
                o_cmd.cap_gini = 1'b1;
                o_cmd.div_load = 1'b1;
                o_cmd.div_src  = DIV_CV;
            end
            ST_MEAN_RUN, ST_GINI_RUN, ST_CV_RUN: o_cmd.div_step = 1'b1;
            ST_ROOT_LD:  o_cmd.root_load = 1'b1;
            ST_ROOT_RUN: o_cmd.root_step = 1'b1;
            ST_EMIT:     o_cmd.emit      = 1'b1;
            default: ;
        endcase
    end

endmodule

// File: rtl/core/sgcv_dp.sv
module sgcv_dp #(
    parameter int MAX_SAMPLES = 256
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_accept,
    input  logic signed [sgcv_pkg::X_W-1:0]   i_sample_value,
    input  sgcv_pkg::t_dp_cmd                 i_cmd,
    output sgcv_pkg::t_dp_sts                 o_sts,
    output logic                              o_result_valid,
    output logic signed [sgcv_pkg::OUT_W-1:0] o_mean_value,
    output logic signed [sgcv_pkg::OUT_W-1:0] o_gini_value,
    output logic signed [sgcv_pkg::OUT_W-1:0] o_cv_value
);
    import sgcv_pkg::*;

    localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_SAMPLES);

    // Accumulators
    logic [CNT_W-1:0]        r_cnt;
    logic signed [SUM_W-1:0] r_sum;
    logic signed [WS_W-1:0]  r_wsum;
    logic [SQ_W-1:0]         r_sq;

    logic [CNT_W-1:0]        n_cnt;
    logic signed [N_W+X_W:0] wprod;
    logic signed [2*X_W-1:0] xsq;

    assign n_cnt = r_cnt + CNT_W'(1);
    assign wprod = $signed({1'b0, N_W'(n_cnt)}) * i_sample_value;
    assign xsq   = i_sample_value * i_sample_value;

    // Accumulate one sample, drop it once the set is full, clear on emit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.emit) begin
            r_cnt  <= '0;
            r_sum  <= '0;
            r_wsum <= '0;
            r_sq   <= '0;
        end else if (i_accept && (r_cnt < CNT_MAX)) begin
            r_cnt  <= n_cnt;
            r_sum  <= r_sum + SUM_W'(i_sample_value);
            r_wsum <= r_wsum + WS_W'(wprod);
            r_sq   <= r_sq + {{(SQ_W-2*X_W){1'b0}}, xsq};
        end
    end

    // Set-level products
    logic [N_W-1:0]           n_val;
    logic [N_W-1:0]           n_p1;
    logic [N_W-1:0]           n_m1;
    logic [SUM_W-2:0]         abs_s;
    logic                     s_neg;
    logic                     s_zero;
    logic                     n_small;

    assign n_val   = N_W'(r_cnt);
    assign n_p1    = n_val + N_W'(1);
    assign n_m1    = n_val - N_W'(1);
    assign s_neg   = r_sum[SUM_W-1];
    assign abs_s   = s_neg ? (SUM_W-1)'(-r_sum) : (SUM_W-1)'(r_sum);
    assign s_zero  = (r_sum == '0);
    assign n_small = (n_val < N_W'(2));

    logic signed [N_W+SUM_W:0]   r_ns;
    logic signed [N_W+SUM_W:0]   r_n1s;
    logic [N_W+SQ_W-1:0]         r_nq;
    logic [2*SUM_W-3:0]          r_ss;
    logic signed [N_W+SQ_W:0]    r_d;
    logic signed [WS_W+2:0]      r_ga;
    logic [N_W+54:0]             r_dn;
    logic [N_W+2*SUM_W-3:0]      r_den;

    // Form products, then differences, then the products of the variance
    always_ff @(posedge i_clk) begin
        if (i_cmd.prod) begin
            r_ns  <= $signed({1'b0, n_val}) * r_sum;
            r_n1s <= $signed({1'b0, n_p1}) * r_sum;
            r_nq  <= n_val * r_sq;
            r_ss  <= abs_s * abs_s;
        end
        if (i_cmd.diff) begin
            r_d  <= $signed({1'b0, r_nq}) - $signed({{(N_W+SQ_W-2*SUM_W+3){1'b0}}, r_ss});
            r_ga <= $signed({r_wsum[WS_W-1], r_wsum, 1'b0}) - (WS_W+3)'(r_n1s);
        end
        if (i_cmd.prod2) begin
            r_dn  <= r_d[54:0] * n_val;
            r_den <= n_m1 * r_ss;
        end
    end

    // Shared restoring divider, one quotient bit per cycle
    logic [DVD_W-1:0]  r_dq;
    logic [DVS_W-1:0]  r_dvs;
    logic [REM_W-1:0]  r_rem;
    logic [DCNT_W-1:0] r_dcnt;
    logic              r_qneg;

    logic [REM_W-1:0]  rem_sh;
    logic              rem_ge;
    logic [WS_W+1:0]   abs_ga;
    logic [N_W+SUM_W-1:0] abs_ns;

    assign rem_sh = {r_rem[REM_W-2:0], r_dq[DVD_W-1]};
    assign rem_ge = (rem_sh >= {1'b0, r_dvs});
    assign abs_ga = r_ga[WS_W+2] ? (WS_W+2)'(-r_ga) : (WS_W+2)'(r_ga);
    assign abs_ns = r_ns[N_W+SUM_W] ? (N_W+SUM_W)'(-r_ns) : (N_W+SUM_W)'(r_ns);

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_load) begin
            r_rem  <= '0;
            r_dcnt <= '0;
            case (i_cmd.div_src)
                DIV_MEAN: begin
                    r_dq   <= DVD_W'({abs_s, 9'b0}) + DVD_W'(n_val);
                    r_dvs  <= DVS_W'({n_val, 1'b0});
                    r_qneg <= s_neg;
                end
                DIV_GINI: begin
                    r_dq   <= DVD_W'({abs_ga, 17'b0}) + DVD_W'(abs_ns);
                    r_dvs  <= DVS_W'({abs_ns, 1'b0});
                    r_qneg <= r_ga[WS_W+2] ^ r_ns[N_W+SUM_W];
                end
                default: begin
                    r_dq   <= DVD_W'({r_dn, 32'b0});
                    r_dvs  <= DVS_W'(r_den);
                    r_qneg <= s_neg;
                end
            endcase
        end else if (i_cmd.div_step) begin
            r_rem  <= rem_ge ? (rem_sh - {1'b0, r_dvs}) : rem_sh;
            r_dq   <= {r_dq[DVD_W-2:0], rem_ge};
            r_dcnt <= r_dcnt + DCNT_W'(1);
        end
    end

    assign o_sts.div_last = (r_dcnt == DCNT_W'(DVD_W - 1));

    // Quotient checks for saturation
    logic q_big;
    logic [OUT_W-1:0] q_neg_val;
    assign q_big     = |r_dq[DVD_W-1:OUT_W];
    assign q_neg_val = OUT_W'(-r_dq[OUT_W-1:0]);

    // Digit-by-digit square root
    logic [RT_W-1:0]   r_rv;
    logic [RT_W-1:0]   r_rres;
    logic [RT_W-1:0]   r_rbit;
    logic [RCNT_W-1:0] r_rcnt;
    logic              r_cv_sat;

    logic [RT_W:0]     rt_sum;
    logic              rt_ge;
    assign rt_sum = {1'b0, r_rres} + {1'b0, r_rbit};
    assign rt_ge  = ({1'b0, r_rv} >= rt_sum);

    always_ff @(posedge i_clk) begin
        if (i_cmd.root_load) begin
            r_cv_sat <= |r_dq[DVD_W-1:RT_W];
            r_rv     <= r_dq[RT_W-1:0];
            r_rres   <= '0;
            r_rbit   <= RT_W'(1) << (RT_W - 2);
            r_rcnt   <= '0;
        end else if (i_cmd.root_step) begin
            r_rv   <= rt_ge ? (r_rv - rt_sum[RT_W-1:0]) : r_rv;
            r_rres <= rt_ge ? ((r_rres >> 1) + r_rbit) : (r_rres >> 1);
            r_rbit <= r_rbit >> 2;
            r_rcnt <= r_rcnt + RCNT_W'(1);
        end
    end

    assign o_sts.root_last = (r_rcnt == RCNT_W'(RT_STEPS - 1));

    // Result registers
    logic signed [OUT_W-1:0] r_mean;
    logic signed [OUT_W-1:0] r_gini;
    logic signed [OUT_W-1:0] r_cv;
    logic                    r_valid;
    logic                    d_pos;

    assign d_pos = !r_d[N_W+SQ_W] && (r_d != '0);

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_mean) begin
            r_mean <= r_qneg ? q_neg_val : r_dq[OUT_W-1:0];
        end
        if (i_cmd.cap_gini) begin
            if (n_small || s_zero) begin
                r_gini <= '0;
            end else if (!r_qneg) begin
                r_gini <= (q_big || r_dq[OUT_W-1]) ? {1'b0, {(OUT_W-1){1'b1}}}
                                                    : r_dq[OUT_W-1:0];
            end else begin
                r_gini <= (q_big || (r_dq[OUT_W-1] && |r_dq[OUT_W-2:0]))
                          ? {1'b1, {(OUT_W-1){1'b0}}} : q_neg_val;
            end
        end
        if (i_cmd.emit) begin
            if (n_small || s_zero || !d_pos) begin
                r_cv <= '0;
            end else if (r_cv_sat) begin
                r_cv <= s_neg ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
            end else begin
                r_cv <= s_neg ? OUT_W'(-r_rres) : OUT_W'(r_rres);
            end
        end
    end

    // Strobe the item for one cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.emit;
        end
    end

    assign o_result_valid = r_valid;
    assign o_mean_value   = r_mean;
    assign o_gini_value   = r_gini;
    assign o_cv_value     = r_cv;

endmodule

// File: rtl/core/sample_gini_and_cv_engine.sv
// Channel   | Direction | Handshake              | Payload
// ----------+-----------+------------------------+-----------------------------------
// sample    | in        | start high, busy low   | i_sample_value, i_last_sample
// result    | out       | o_result_valid strobe  | o_mean_value, o_gini_value, o_cv_value
//
// A sample without the last flag is taken in while idle; samples stream back to back.
// The last sample starts the finishing sequence, run with busy high:
// three 100-step passes of the shared restoring divider and 31 square root steps.
// The result strobe follows, one cycle, and a new set may start in that cycle.
// Reset is synchronous, active low, and clears the sums and the controller.
// The receiver cannot stall; each result is shown for exactly one cycle.
module sample_gini_and_cv_engine #(
    parameter int MAX_SAMPLES = 256
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic signed [sgcv_pkg::X_W-1:0]   i_sample_value,
    input  logic                              i_last_sample,
    output logic                              o_result_valid,
    output logic signed [sgcv_pkg::OUT_W-1:0] o_mean_value,
    output logic signed [sgcv_pkg::OUT_W-1:0] o_gini_value,
    output logic signed [sgcv_pkg::OUT_W-1:0] o_cv_value
);
    import sgcv_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;
    logic    accept;

    assign accept = start && !busy;

    sgcv_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_last_sample (i_last_sample),
        .i_sts         (sts),
        .o_cmd         (cmd),
        .o_busy        (busy)
    );

    sgcv_dp #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_sample_value (i_sample_value),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .o_result_valid (o_result_valid),
        .o_mean_value   (o_mean_value),
        .o_gini_value   (o_gini_value),
        .o_cv_value     (o_cv_value)
    );

    // A result comes only out of the finishing sequence
    a_valid_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(busy))
        else $error("result strobe without a finishing sequence");

    // A last sample starts the finishing sequence
    a_last_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_last_sample) |=> busy)
        else $error("last sample did not raise busy");

    // One strobe per set
    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !o_result_valid)
        else $error("result strobe longer than one cycle");

endmodule
